@@ hdl/group_table_identity_inverse_macros.svh @@
// Assertion macros shared by the group table checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef GROUP_TABLE_IDENTITY_INVERSE_MACROS_SVH
`define GROUP_TABLE_IDENTITY_INVERSE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gti_pkg.sv @@
// Shared types and constants for the group table block.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package gti_pkg;

  localparam int ORDER_MAX = 32;
  localparam int ELEM_W    = $clog2(ORDER_MAX);
  localparam int ORDER_W   = ELEM_W + 1;
  localparam int ADDR_W    = 2 * ELEM_W;
  localparam int INV_W     = ELEM_W + 1;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 3;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_PROD  = 2'd2,
    CMD_INV   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_NO_ID = 3'd1,
    ST_EMPTY = 3'd2,
    ST_RANGE = 3'd3,
    ST_NOINV = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QRY,
    S_ID_RD,
    S_ID_CHK,
    S_INV_RD,
    S_INV_CHK,
    S_FIN
  } state_t;

  localparam logic [CFG_AW-1:0] REG_GROUP_ORDER = '0;

endpackage
`default_nettype wire

@@ hdl/gti_in_if.sv @@
// Input channel of the group table block: valid/ready plus one command item.
// Depends on gti_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface gti_in_if
  import gti_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ELEM_W-1:0] row;
  logic [ELEM_W-1:0] col;
  logic [ELEM_W-1:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface
`default_nettype wire

@@ hdl/gti_out_if.sv @@
// Result channel of the group table block: valid/ready plus one result item.
// Depends on gti_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface gti_out_if
  import gti_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ELEM_W-1:0] result;
  logic [ELEM_W-1:0] identity;

  modport source (output valid, status, result, identity, input ready);
  modport sink   (input valid, status, result, identity, output ready);
endinterface
`default_nettype wire

@@ hdl/group_table_identity_inverse.sv @@
// Group table block: Cayley table store with identity search and inverse build.
// Depends on gti_pkg, gti_in_if and gti_out_if.
// Usage:
//   in_ch carries one command item per handshake: load a table entry, build
//   identity and inverses, query a product, or query an inverse. out_ch returns
//   exactly one result item per input item, in order, with status, result and
//   the current identity element.
//   The group order is written through the APB-style cfg_ port at address 0;
//   write it only while no item is in flight. Writing it marks the table unbuilt.
// Timing:
//   One item at a time; in_ch.ready is high only while the sequencer is idle.
//   Load and error items go straight to the finish state; queries add one registered
//   memory read. A build at order n makes p identity-search probes (n to n*n),
//   each probe a read and a compare state on the single read port, then scans the
//   n*n table for inverses; a build that finds no identity skips that scan.
//   The result sits in an output register, so the next item is accepted while
//   an earlier result still waits; a stalled out_ch holds the finishing item.
// Reset:
//   rst_n is synchronous, active low: order 0, identity 0, not built, channels
//   empty. Table contents are not cleared; the user must write them before they are read (not enforced).
`timescale 1ns / 1ps
`default_nettype none
module group_table_identity_inverse
  import gti_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  gti_in_if.sink                 in_ch,
  gti_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  // Sequencer and pending item
  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ORDER_W-1:0] e_r, e_nxt;
  logic [ORDER_W-1:0] t_r, t_nxt;
  logic [INV_W-1:0]   inv_r, inv_nxt;
  status_t            stat_r, stat_nxt;
  logic [ELEM_W-1:0]  res_r, res_nxt;

  // Architectural state
  logic [ORDER_W-1:0] order_r, order_nxt;
  logic [ELEM_W-1:0]  identity_r, identity_nxt;
  logic               built_r, built_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [ELEM_W-1:0]  out_result_r, out_result_nxt;
  logic [ELEM_W-1:0]  out_identity_r, out_identity_nxt;

  // Memories
  logic [ELEM_W-1:0]  prod_mem [ORDER_MAX*ORDER_MAX];
  logic [INV_W-1:0]   inv_mem  [ORDER_MAX];
  logic [ELEM_W-1:0]  pt_rd_r;
  logic [INV_W-1:0]   inv_rd_r;
  logic               pt_we;
  logic [ADDR_W-1:0]  pt_raddr;
  logic               inv_we;
  logic [INV_W-1:0]   inv_cur;

  logic [ORDER_W-1:0] n_act;
  logic               accept;
  logic               cfg_wr;
  logic               row_bad, col_bad, val_bad;
  logic               t_last, e_last;
  cmd_t               in_cmd;

  // Orders above the table side act as a full table
  assign n_act = (order_r > ORDER_W'(ORDER_MAX)) ? ORDER_W'(ORDER_MAX) : order_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_cmd      = cmd_t'(in_ch.command);
  assign row_bad     = {1'b0, in_ch.row}   >= n_act;
  assign col_bad     = {1'b0, in_ch.col}   >= n_act;
  assign val_bad     = {1'b0, in_ch.value} >= n_act;
  assign t_last      = (t_r + ORDER_W'(1)) == n_act;
  assign e_last      = (e_r + ORDER_W'(1)) == n_act;

  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite &&
                       (cfg_paddr == REG_GROUP_ORDER);
  assign cfg_prdata  = (cfg_paddr == REG_GROUP_ORDER) ?
                       {{(CFG_DW-ORDER_W){1'b0}}, order_r} : '0;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.result   = out_result_r;
  assign out_ch.identity = out_identity_r;

  // Product table read address: query operands on accept, scan pair otherwise
  always_comb begin
    if (state_r == S_IDLE) begin
      pt_raddr = {in_ch.row, in_ch.col};
    end else begin
      pt_raddr = {t_r[ELEM_W-1:0], e_r[ELEM_W-1:0]};
    end
  end

  // Inverse candidate: keep the last matching column
  assign inv_cur = (pt_rd_r == identity_r) ? {1'b0, e_r[ELEM_W-1:0]} : inv_r;

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    e_nxt            = e_r;
    t_nxt            = t_r;
    inv_nxt          = inv_r;
    stat_nxt         = stat_r;
    res_nxt          = res_r;
    order_nxt        = order_r;
    identity_nxt     = identity_r;
    built_nxt        = built_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_result_nxt   = out_result_r;
    out_identity_nxt = out_identity_r;
    pt_we            = 1'b0;
    inv_we           = 1'b0;

    // Drop the shown result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          res_nxt   = '0;
          stat_nxt  = ST_OK;
          state_nxt = S_FIN;
          if (n_act == '0) begin
            stat_nxt = ST_EMPTY;
            if (in_cmd == CMD_BUILD) begin
              built_nxt = 1'b0;
            end
          end else begin
            unique case (in_cmd)
              CMD_LOAD: begin
                if (row_bad || col_bad || val_bad) begin
                  stat_nxt = ST_RANGE;
                end else begin
                  pt_we     = 1'b1;
                  built_nxt = 1'b0;
                end
              end
              CMD_BUILD: begin
                e_nxt     = '0;
                t_nxt     = '0;
                state_nxt = S_ID_RD;
              end
              CMD_PROD: begin
                if (row_bad || col_bad) begin
                  stat_nxt = ST_RANGE;
                end else begin
                  state_nxt = S_QRY;
                end
              end
              CMD_INV: begin
                if (row_bad) begin
                  stat_nxt = ST_RANGE;
                end else begin
                  state_nxt = S_QRY;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_QRY: begin
        state_nxt = S_FIN;
        if (cmd_r == CMD_PROD) begin
          res_nxt = pt_rd_r;
        end else if (!built_r || inv_rd_r[INV_W-1]) begin
          stat_nxt = ST_NOINV;
        end else begin
          res_nxt = inv_rd_r[ELEM_W-1:0];
        end
      end
      S_ID_RD: begin
        state_nxt = S_ID_CHK;
      end
      S_ID_CHK: begin
        if (pt_rd_r != t_r[ELEM_W-1:0]) begin
          // Candidate fails: advance to the next column or give up
          if (e_last) begin
            built_nxt = 1'b0;
            stat_nxt  = ST_NO_ID;
            state_nxt = S_FIN;
          end else begin
            e_nxt     = e_r + ORDER_W'(1);
            t_nxt     = '0;
            state_nxt = S_ID_RD;
          end
        end else if (t_last) begin
          identity_nxt = e_r[ELEM_W-1:0];
          t_nxt        = '0;
          e_nxt        = '0;
          inv_nxt      = {1'b1, {ELEM_W{1'b0}}};
          state_nxt    = S_INV_RD;
        end else begin
          t_nxt     = t_r + ORDER_W'(1);
          state_nxt = S_ID_RD;
        end
      end
      S_INV_RD: begin
        state_nxt = S_INV_CHK;
      end
      S_INV_CHK: begin
        if (e_last) begin
          inv_we = 1'b1;
          if (t_last) begin
            built_nxt = 1'b1;
            stat_nxt  = ST_OK;
            state_nxt = S_FIN;
          end else begin
            t_nxt     = t_r + ORDER_W'(1);
            e_nxt     = '0;
            inv_nxt   = {1'b1, {ELEM_W{1'b0}}};
            state_nxt = S_INV_RD;
          end
        end else begin
          inv_nxt   = inv_cur;
          e_nxt     = e_r + ORDER_W'(1);
          state_nxt = S_INV_RD;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = stat_r;
          out_result_nxt   = res_r;
          out_identity_nxt = identity_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      order_nxt = cfg_pwdata[ORDER_W-1:0];
      built_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= '0;
      identity_r  <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      order_r     <= order_nxt;
      identity_r  <= identity_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    e_r            <= e_nxt;
    t_r            <= t_nxt;
    inv_r          <= inv_nxt;
    stat_r         <= stat_nxt;
    res_r          <= res_nxt;
    out_status_r   <= out_status_nxt;
    out_result_r   <= out_result_nxt;
    out_identity_r <= out_identity_nxt;
  end

  // Product table: one write port (loads), one registered read port
  always_ff @(posedge clk) begin
    if (pt_we) begin
      prod_mem[{in_ch.row, in_ch.col}] <= in_ch.value;
    end
    pt_rd_r <= prod_mem[pt_raddr];
  end

  // Inverse table: written by the build scan, read by inverse queries
  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[t_r[ELEM_W-1:0]] <= inv_cur;
    end
    inv_rd_r <= inv_mem[in_ch.row];
  end

endmodule
`default_nettype wire

@@ hdl/gti_checker.sv @@
// Port-level checker for the group table block, bound to the top level.
// Depends on gti_pkg and group_table_identity_inverse_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "group_table_identity_inverse_macros.svh"
module gti_checker
  import gti_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [ELEM_W-1:0] out_result
);

  `GTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled item dropped")
  `GTI_ASSERT_NOW(a_res_zero, out_valid && (out_status != ST_OK), out_result == '0, "result not zero on error")
  `GTI_ASSERT_NOW(a_stat_legal, out_valid, out_status <= ST_NOINV, "illegal status code")
  `GTI_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "accepted a second item while busy")

endmodule

bind group_table_identity_inverse gti_checker u_gti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_result (out_ch.result)
);
`default_nettype wire

@@ dv/tb_group_table_identity_inverse.sv @@
// Self-checking testbench for the group table block: sends load, build and query items,
// predicts every result with its own table model and checks each field as it comes out.
// Depends on gti_pkg, gti_in_if, gti_out_if and group_table_identity_inverse.
`timescale 1ns / 1ps
module tb_group_table_identity_inverse;
  import gti_pkg::*;

  localparam int CELLS          = ORDER_MAX * ORDER_MAX;
  localparam int RANDOM_ITEMS   = 420;
  // A build at the largest order runs with no handshake at all.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [INV_W-1:0] NO_INVERSE = INV_W'(1) << ELEM_W;

  typedef struct packed {
    status_t           status;
    logic [ELEM_W-1:0] result;
    logic [ELEM_W-1:0] identity;
  } answer_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  gti_in_if  cmd_bus ();
  gti_out_if ans_bus ();

  group_table_identity_inverse u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_bus),
    .out_ch      (ans_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow of the block's state. The loaded flags track which table entries hold a
  // defined value, so that no item ever makes the block read an unwritten entry.
  logic [ELEM_W-1:0]  cayley_q      [CELLS];
  bit                 cayley_loaded [CELLS];
  logic [INV_W-1:0]   inverse_q     [ORDER_MAX];
  logic [ELEM_W-1:0]  identity_q;
  bit                 built_q;
  logic [ORDER_W-1:0] order_q;

  answer_t expected_answers[$];
  int      relabel[ORDER_MAX];
  int      error_count;
  int      items_sent;
  int      idle_cycles;
  int      burst_left;
  int      stall_left;
  int      calm_left;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  // Orders above the table side behave as the full table.
  function automatic int active_order();
    return (order_q > ORDER_MAX) ? ORDER_MAX : int'(order_q);
  endfunction

  // Apply one command to the shadow state and return the result item it causes.
  function automatic answer_t apply_command(cmd_t cmd, int r, int c, int v);
    answer_t ans;
    int      n;
    int      e;
    int      t;
    int      inv;
    bit      found;
    bit      fits;
    n          = active_order();
    ans.status = ST_OK;
    ans.result = '0;
    if (n == 0) begin
      // Empty group: refuse everything; a build still drops the built mark.
      ans.status = ST_EMPTY;
      if (cmd == CMD_BUILD) built_q = 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          if (r >= n || c >= n || v >= n) begin
            ans.status = ST_RANGE;
          end else begin
            cayley_q[r*ORDER_MAX + c]      = ELEM_W'(v);
            cayley_loaded[r*ORDER_MAX + c] = 1'b1;
            built_q                        = 1'b0;
          end
        end
        CMD_BUILD: begin
          // Smallest e with t*e == t for every t; stop probing a column at its first miss.
          found = 1'b0;
          for (e = 0; e < n && !found; e++) begin
            fits = 1'b1;
            for (t = 0; t < n && fits; t++) begin
              if (cayley_q[t*ORDER_MAX + e] != t) fits = 1'b0;
            end
            if (fits) begin
              found      = 1'b1;
              identity_q = ELEM_W'(e);
            end
          end
          if (!found) begin
            // No identity: keep the old identity, drop the built mark.
            built_q    = 1'b0;
            ans.status = ST_NO_ID;
          end else begin
            // Inverse of t is the last column whose product is the identity.
            for (t = 0; t < n; t++) begin
              inv = -1;
              for (e = 0; e < n; e++) begin
                if (cayley_q[t*ORDER_MAX + e] == identity_q) inv = e;
              end
              inverse_q[t] = (inv < 0) ? NO_INVERSE : INV_W'(inv);
            end
            built_q = 1'b1;
          end
        end
        CMD_PROD: begin
          if (r >= n || c >= n) ans.status = ST_RANGE;
          else ans.result = cayley_q[r*ORDER_MAX + c];
        end
        default: begin
          if (r >= n) ans.status = ST_RANGE;
          else if (!built_q || inverse_q[r][ELEM_W]) ans.status = ST_NOINV;
          else ans.result = inverse_q[r][ELEM_W-1:0];
        end
      endcase
    end
    ans.identity = identity_q;
    return ans;
  endfunction

  // True when a build at order n touches only loaded entries: the identity search
  // stops at the first miss in each column, the inverse scan reads the whole table.
  function automatic bit build_is_safe(int n);
    int e;
    int t;
    bit found;
    bit fits;
    found = 1'b0;
    for (e = 0; e < n && !found; e++) begin
      fits = 1'b1;
      for (t = 0; t < n && fits; t++) begin
        if (!cayley_loaded[t*ORDER_MAX + e]) return 1'b0;
        if (cayley_q[t*ORDER_MAX + e] != t) fits = 1'b0;
      end
      if (fits) found = 1'b1;
    end
    if (!found) return 1'b1;
    for (t = 0; t < n; t++) begin
      for (e = 0; e < n; e++) begin
        if (!cayley_loaded[t*ORDER_MAX + e]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors, checker and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Predict at the edge that accepts an item, so the state matches the block's order.
  always @(posedge clk) begin
    if (rst_n && cmd_bus.valid && cmd_bus.ready) begin
      expected_answers.push_back(apply_command(cmd_t'(cmd_bus.command), cmd_bus.row,
                                               cmd_bus.col, cmd_bus.value));
    end
  end

  // Compare each accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && ans_bus.valid && ans_bus.ready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result with nothing pending, status", ans_bus.status, -1);
      end else begin
        want = expected_answers.pop_front();
        if (ans_bus.status !== want.status)
          report_mismatch("status", ans_bus.status, want.status);
        if (ans_bus.result !== want.result)
          report_mismatch("result", ans_bus.result, want.result);
        if (ans_bus.identity !== want.identity)
          report_mismatch("identity", ans_bus.identity, want.identity);
      end
    end
  end

  // End the run after too many cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (ans_bus.valid && ans_bus.ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: mostly ready, short random stalls, now and then a long calm stretch.
  initial begin : drive_result_ready
    int pick;
    ans_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left > 0) begin
        calm_left--;
        ans_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        ans_bus.ready = 1'b0;
      end else begin
        pick = $urandom_range(19, 0);
        if (pick == 0) calm_left = $urandom_range(150, 30);
        else if (pick < 6) stall_left = $urandom_range(7, 1);
        ans_bus.ready = (stall_left == 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one item; open a new burst after a random gap when the current one is used up.
  task automatic send_item(cmd_t cmd, int r, int c, int v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
      if (gap > 0) begin
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_bus.valid   = 1'b1;
    cmd_bus.command = cmd;
    cmd_bus.row     = ELEM_W'(r);
    cmd_bus.col     = ELEM_W'(c);
    cmd_bus.value   = ELEM_W'(v);
    do @(posedge clk); while (!cmd_bus.ready);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_for_answers();
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    burst_left    = 0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the group order; the block must be idle.
  task automatic write_group_order(int order);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = REG_GROUP_ORDER;
    cfg_pwdata  = CFG_DW'(order);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    order_q = ORDER_W'(order);
    built_q = 1'b0;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Read the group order back and compare with the last value written.
  task automatic check_group_order();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    cfg_paddr   = REG_GROUP_ORDER;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(order_q))
      report_mismatch("group_order readback", cfg_prdata, order_q);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  function automatic void shuffle_relabel(int n);
    int i;
    int j;
    int tmp;
    for (i = 0; i < ORDER_MAX; i++) relabel[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j          = $urandom_range(i, 0);
      tmp        = relabel[i];
      relabel[i] = relabel[j];
      relabel[j] = tmp;
    end
  endfunction

  // Load the cyclic group of order n with its elements renamed through relabel,
  // so the identity is relabel[0] and the inverse of relabel[a] is relabel[(n-a)%n].
  task automatic load_group(int n);
    int a;
    int b;
    for (a = 0; a < n; a++) begin
      for (b = 0; b < n; b++) send_item(CMD_LOAD, relabel[a], relabel[b], relabel[(a+b)%n]);
    end
  endtask

  // One random item at order n; never reads a table entry that was not loaded.
  task automatic send_random_item(int n);
    int pick;
    int r;
    int c;
    int v;
    int tries;
    pick = $urandom_range(99, 0);
    r    = $urandom_range(31, 0);
    c    = $urandom_range(31, 0);
    v    = $urandom_range(31, 0);
    if (pick < 15) begin
      if (n > 0 && $urandom_range(3, 0) != 0) begin
        r = $urandom_range(n - 1, 0);
        c = $urandom_range(n - 1, 0);
        v = $urandom_range(n - 1, 0);
      end
      send_item(CMD_LOAD, r, c, v);
    end else if (pick < 23 && build_is_safe(n)) begin
      send_item(CMD_BUILD, r, c, v);
    end else if (pick < 62) begin
      if (n > 0 && $urandom_range(5, 0) != 0) begin
        r = $urandom_range(n - 1, 0);
        c = $urandom_range(n - 1, 0);
      end
      tries = 0;
      while (r < n && c < n && !cayley_loaded[r*ORDER_MAX + c] && tries < 40) begin
        r = $urandom_range(n - 1, 0);
        c = $urandom_range(n - 1, 0);
        tries++;
      end
      // Fall back to loading the entry when no loaded one turned up.
      if (r < n && c < n && !cayley_loaded[r*ORDER_MAX + c])
        send_item(CMD_LOAD, r, c, $urandom_range(n - 1, 0));
      else
        send_item(CMD_PROD, r, c, v);
    end else begin
      if (n > 0 && $urandom_range(5, 0) != 0) r = $urandom_range(n - 1, 0);
      send_item(CMD_INV, r, c, v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Order 0 after reset: every command reports an empty group, identity stays 0.
  task automatic test_empty_group();
    check_group_order();
    send_item(CMD_LOAD, 0, 0, 0);
    send_item(CMD_BUILD, 31, 31, 31);
    send_item(CMD_PROD, 0, 0, 0);
    send_item(CMD_INV, 0, 0, 0);
    wait_for_answers();
  endtask

  // Order 1: range errors on each operand, inverse before and after a build.
  task automatic test_single_element();
    write_group_order(1);
    check_group_order();
    send_item(CMD_INV, 0, 0, 0);
    send_item(CMD_LOAD, 0, 0, 0);
    send_item(CMD_PROD, 0, 0, 0);
    send_item(CMD_LOAD, 0, 0, 31);
    send_item(CMD_LOAD, 31, 0, 0);
    send_item(CMD_LOAD, 0, 31, 0);
    send_item(CMD_PROD, 31, 0, 0);
    send_item(CMD_PROD, 0, 31, 0);
    send_item(CMD_INV, 31, 0, 0);
    send_item(CMD_BUILD, 0, 0, 0);
    send_item(CMD_INV, 0, 0, 0);
    // A load changes the table, so the inverses are stale again.
    send_item(CMD_LOAD, 0, 0, 0);
    send_item(CMD_INV, 0, 0, 0);
    wait_for_answers();
  endtask

  // Tables where every column is a right identity, where the identity is not 0, and with none.
  task automatic test_identity_search();
    int a;
    int b;
    // Left projection: smallest identity 0; only row 0 has an inverse, in the last column.
    write_group_order(3);
    for (a = 0; a < 3; a++) begin
      for (b = 0; b < 3; b++) send_item(CMD_LOAD, a, b, a);
    end
    send_item(CMD_BUILD, 0, 0, 0);
    for (a = 0; a < 3; a++) send_item(CMD_INV, a, 0, 0);
    wait_for_answers();
    // Cyclic group of order 4 shifted so that 2 is the identity.
    write_group_order(4);
    for (a = 0; a < ORDER_MAX; a++) relabel[a] = (a + 2) % 4;
    load_group(4);
    send_item(CMD_BUILD, 0, 0, 0);
    for (a = 0; a < 4; a++) send_item(CMD_INV, a, 0, 0);
    send_item(CMD_PROD, 3, 3, 0);
    wait_for_answers();
    // Successor table: no right identity; the identity from before must stay.
    write_group_order(3);
    for (a = 0; a < 3; a++) begin
      for (b = 0; b < 3; b++) send_item(CMD_LOAD, a, b, (a + 1) % 3);
    end
    send_item(CMD_BUILD, 0, 0, 0);
    send_item(CMD_INV, 1, 0, 0);
    wait_for_answers();
  endtask

  // Order register above the table side, top operands, and a failing build at full size.
  task automatic test_largest_order();
    int e;
    write_group_order(63);
    check_group_order();
    // Row 0 never yields 0, so the identity search misses every column at its first probe.
    for (e = 0; e < ORDER_MAX; e++) send_item(CMD_LOAD, 0, e, $urandom_range(31, 1));
    send_item(CMD_BUILD, 0, 0, 0);
    send_item(CMD_LOAD, 31, 31, 31);
    send_item(CMD_PROD, 31, 31, 0);
    send_item(CMD_PROD, 0, 31, 0);
    wait_for_answers();
    write_group_order(ORDER_MAX);
    check_group_order();
    send_item(CMD_PROD, 31, 31, 0);
    send_item(CMD_INV, 31, 0, 0);
    wait_for_answers();
  endtask

  // Phases of random order: mostly a relabeled cyclic group, sometimes damaged,
  // then a random mix of loads, builds and queries.
  task automatic test_random_phases();
    int goal;
    int pick;
    int order;
    int n;
    int count;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      pick = $urandom_range(19, 0);
      if (pick == 0) order = 0;
      else if (pick == 1) order = $urandom_range(63, 13);
      else if (pick < 4) order = $urandom_range(12, 9);
      else order = $urandom_range(8, 1);
      wait_for_answers();
      write_group_order(order);
      if ($urandom_range(3, 0) == 0) check_group_order();
      n = active_order();
      if (n > 0 && n <= 12) begin
        shuffle_relabel(n);
        load_group(n);
        if ($urandom_range(2, 0) == 0) begin
          repeat ($urandom_range(3, 1))
            send_item(CMD_LOAD, $urandom_range(n - 1, 0), $urandom_range(n - 1, 0),
                      $urandom_range(n - 1, 0));
        end
        send_item(CMD_BUILD, $urandom_range(31, 0), $urandom_range(31, 0),
                  $urandom_range(31, 0));
      end
      count = $urandom_range(60, 20);
      repeat (count) begin
        send_random_item(n);
        // Hold off now and then until the block has answered everything.
        if ($urandom_range(99, 0) == 0) wait_for_answers();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    int i;
    rst_n           = 1'b0;
    cmd_bus.valid   = 1'b0;
    cmd_bus.command = CMD_LOAD;
    cmd_bus.row     = '0;
    cmd_bus.col     = '0;
    cmd_bus.value   = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    order_q         = '0;
    identity_q      = '0;
    built_q         = 1'b0;
    error_count     = 0;
    items_sent      = 0;
    burst_left      = 0;
    stall_left      = 0;
    calm_left       = 0;
    for (i = 0; i < CELLS; i++) begin
      cayley_q[i]      = '0;
      cayley_loaded[i] = 1'b0;
    end
    for (i = 0; i < ORDER_MAX; i++) inverse_q[i] = NO_INVERSE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_group();
    test_single_element();
    test_identity_search();
    test_largest_order();
    test_random_phases();

    wait_for_answers();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
